FILE: rtl/quaternion_skinning_vertex_deformer_macros.svh
// Assertion macros used by the skinning deformer back end (qsvd_back).
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef QUATERNION_SKINNING_VERTEX_DEFORMER_MACROS_SVH
`define QUATERNION_SKINNING_VERTEX_DEFORMER_MACROS_SVH

// condition holds at every edge out of reset
`define QSVD_CHECK(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define QSVD_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/qsvd_pkg.sv
// Types, constants and the arithmetic microcode of the skinning deformer.
// No dependencies.
package qsvd_pkg;

    localparam int WORDS_PER_BONE = 12;
    localparam int MAX_INFLUENCES = 4;
    localparam int WEIGHT_FULL    = 255;
    localparam int INF_W          = $clog2(MAX_INFLUENCES + 1);
    localparam int WF_W           = $clog2(WEIGHT_FULL + 1);
    localparam int ACC_W          = 44;
    localparam int DIV_W          = ACC_W + WF_W + 1;
    localparam logic [DIV_W-1:0] DIV_OFFSET = DIV_W'(WEIGHT_FULL) << (ACC_W - 1);
    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

    // operand register file indexes
    localparam int R_D  = 0;
    localparam int R_SC = 3;
    localparam int R_T  = 4;
    localparam int R_QX = 7;
    localparam int R_QY = 8;
    localparam int R_QZ = 9;
    localparam int R_QW = 10;
    localparam int R_AX = 11;
    localparam int R_AY = 12;
    localparam int R_AZ = 13;
    localparam int R_AW = 14;
    localparam int R_N  = 15;
    localparam int R_RP = 18;
    localparam int R_RN = 21;
    localparam int R_W  = 24;
    localparam int R_PH = 25;
    localparam int RF_N = 28;

    localparam int NUM_UOPS = 57;
    localparam int STEP_W   = 6;

    typedef struct packed {
        logic              vertex;
        logic              wr_en;
        logic [7:0]        slot;
        logic [3:0]        word;
        logic [31:0]       value;
        logic [2:0][31:0]  pos;
        logic [2:0][15:0]  norm;
        logic [31:0]       ids;
        logic [31:0]       wts;
    } item_t;

    typedef struct packed {
        logic [4:0] a_sel;
        logic [4:0] b_sel;
        logic       neg;
        logic       last;
        logic       wt;
        logic [4:0] dst;
    } uop_t;

    function automatic uop_t mk(input int a, input int b, input bit neg, input bit last,
                                input int dst, input bit wt);
        uop_t u;
        u.a_sel = 5'(a);
        u.b_sel = 5'(b);
        u.neg   = neg;
        u.last  = last;
        u.wt    = wt;
        u.dst   = 5'(dst);
        return u;
    endfunction

    // q * v * conj(q): four sums for the first product, three for the second
    function automatic uop_t rot(input int j, input int v, input int r);
        uop_t u;
        case (j)
            0:  u = mk(R_QW, v + 0, 0, 0, 0, 0);
            1:  u = mk(R_QY, v + 2, 0, 0, 0, 0);
            2:  u = mk(R_QZ, v + 1, 1, 1, R_AX, 0);
            3:  u = mk(R_QW, v + 1, 0, 0, 0, 0);
            4:  u = mk(R_QX, v + 2, 1, 0, 0, 0);
            5:  u = mk(R_QZ, v + 0, 0, 1, R_AY, 0);
            6:  u = mk(R_QW, v + 2, 0, 0, 0, 0);
            7:  u = mk(R_QX, v + 1, 0, 0, 0, 0);
            8:  u = mk(R_QY, v + 0, 1, 1, R_AZ, 0);
            9:  u = mk(R_QX, v + 0, 1, 0, 0, 0);
            10: u = mk(R_QY, v + 1, 1, 0, 0, 0);
            11: u = mk(R_QZ, v + 2, 1, 1, R_AW, 0);
            12: u = mk(R_AX, R_QW, 0, 0, 0, 0);
            13: u = mk(R_AW, R_QX, 1, 0, 0, 0);
            14: u = mk(R_AY, R_QZ, 1, 0, 0, 0);
            15: u = mk(R_AZ, R_QY, 0, 1, r + 0, 0);
            16: u = mk(R_AX, R_QZ, 0, 0, 0, 0);
            17: u = mk(R_AW, R_QY, 1, 0, 0, 0);
            18: u = mk(R_AY, R_QW, 0, 0, 0, 0);
            19: u = mk(R_AZ, R_QX, 1, 1, r + 1, 0);
            20: u = mk(R_AY, R_QX, 0, 0, 0, 0);
            21: u = mk(R_AW, R_QZ, 1, 0, 0, 0);
            22: u = mk(R_AX, R_QY, 1, 0, 0, 0);
            default: u = mk(R_AZ, R_QW, 0, 1, r + 2, 0);
        endcase
        return u;
    endfunction

    // per influence: scale, rotate position, rotate normal, weight six sums
    function automatic uop_t uop_at(input logic [STEP_W-1:0] s);
        int   i;
        uop_t u;
        i = int'(s);
        if (i < 3)
            u = mk(R_D + i, R_SC, 0, 1, R_T + i, 0);
        else if (i < 27)
            u = rot(i - 3, R_T, R_RP);
        else if (i < 51)
            u = rot(i - 27, R_N, R_RN);
        else if (i < 54)
            u = mk(R_RP + i - 51, R_W, 0, 1, i - 51, 1);
        else
            u = mk(R_RN + i - 54, R_W, 0, 1, i - 51, 1);
        return u;
    endfunction

    // identity bone word for entry zero and out-of-range ids
    function automatic logic [31:0] ident_word(input logic [3:0] k);
        logic [31:0] w;
        case (k)
            4'd7, 4'd11: w = ONE_Q16;
            default:     w = 32'd0;
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/qsvd_front.sv
// Input side: accepts beats, classifies table writes, queues items.
// Depends on qsvd_pkg.
module qsvd_front
    import qsvd_pkg::*;
#(
    parameter int BONE_COUNT = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [7:0]  bone_slot,
    input  logic [3:0]  word_select,
    input  logic [31:0] word_value,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [31:0] pos_z,
    input  logic [15:0] norm_x,
    input  logic [15:0] norm_y,
    input  logic [15:0] norm_z,
    input  logic [31:0] bone_ids,
    input  logic [31:0] bone_weights,
    output logic        q_valid,
    output item_t       q_item,
    input  logic        q_pop
);

    localparam int DEPTH = 2;

    item_t       fifo_mem [0:DEPTH-1];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push;
    item_t       item;

    assign in_stall = (cnt_reg == 2'(DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = fifo_mem[rd_ptr_reg];

    always_comb
    begin
        item.vertex = opcode;
        item.wr_en  = !opcode && (bone_slot != 8'd0) && (9'(bone_slot) < 9'(BONE_COUNT))
                      && (word_select < 4'(WORDS_PER_BONE));
        item.slot   = bone_slot;
        item.word   = word_select;
        item.value  = word_value;
        item.pos    = {pos_z, pos_y, pos_x};
        item.norm   = {norm_z, norm_y, norm_x};
        item.ids    = bone_ids;
        item.wts    = bone_weights;
    end

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_mem[wr_ptr_reg] <= item;
    end

endmodule

FILE: rtl/qsvd_back.sv
// Execution side: bone memory, multiply-accumulate sequencer, divide by the
// full weight, and the output register. Depends on qsvd_pkg and the macros.
`include "quaternion_skinning_vertex_deformer_macros.svh"
module qsvd_back
    import qsvd_pkg::*;
#(
    parameter int BONE_COUNT = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  item_t       q_item,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] out_pos_x,
    output logic [31:0] out_pos_y,
    output logic [31:0] out_pos_z,
    output logic [15:0] out_norm_x,
    output logic [15:0] out_norm_y,
    output logic [15:0] out_norm_z
);

    localparam int MEM_D = BONE_COUNT * WORDS_PER_BONE;
    localparam int AW    = $clog2(MEM_D);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_NEXT = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_MATH = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [31:0]             mem [0:MEM_D-1];
    logic [31:0]             rdata_reg;
    logic [AW-1:0]           raddr;

    logic [2:0]              state_reg;
    logic [31:0]             rf_reg [0:RF_N-1];
    logic [2:0][31:0]        pos_reg;
    logic [31:0]             ids_reg, wts_reg;
    logic [INF_W-1:0]        inf_reg;
    logic                    ident_reg;
    logic [AW-1:0]           base_reg;
    logic [3:0]              cnt_reg;
    logic [STEP_W-1:0]       step_reg;
    logic                    phase_reg;
    logic signed [63:0]      prod_reg;
    logic [47:0]             mac_reg;
    logic [ACC_W-1:0]        acc_reg [0:5];
    logic [2:0]              ch_reg;
    logic [DIV_W-1:0]        dvd_reg;
    logic [31:0]             quo_reg;
    logic [31:0]             res_reg [0:5];
    logic                    out_valid_reg;
    logic [2:0][31:0]        out_pos_reg;
    logic [2:0][15:0]        out_norm_reg;

    uop_t                    uop;
    logic [7:0]              cur_id;
    logic [7:0]              cur_wt;
    logic [3:0]              ld_k;
    logic [31:0]             ld_data;
    logic [47:0]             mac_sum;
    logic [4:0]              ph_idx;
    logic [DIV_W-1:0]        div_x1;
    logic [DIV_W-1:0]        div_c;
    logic                    out_load;

    assign uop     = uop_at(step_reg);
    assign cur_id  = ids_reg[{inf_reg[1:0], 3'b000} +: 8];
    assign cur_wt  = wts_reg[{inf_reg[1:0], 3'b000} +: 8];
    assign ld_k    = cnt_reg - 4'd1;
    assign ld_data = ident_reg ? ident_word(ld_k) : rdata_reg;
    assign raddr   = base_reg + AW'(cnt_reg);
    assign mac_sum = uop.neg ? (mac_reg - prod_reg[47:0]) : (mac_reg + prod_reg[47:0]);
    assign ph_idx  = uop.dst - 5'(R_RP) + 5'(R_PH);
    assign div_x1  = dvd_reg + DIV_W'(1);
    assign div_c   = div_x1 >> 8;
    assign q_pop   = (state_reg == S_IDLE) && q_valid;
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    // bone table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (q_pop && !q_item.vertex && q_item.wr_en)
            mem[AW'(q_item.slot) * AW'(WORDS_PER_BONE) + AW'(q_item.word)] <= q_item.value;
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (q_pop && q_item.vertex)
                        state_reg <= S_NEXT;
                end
                S_NEXT:
                begin
                    if ((inf_reg == INF_W'(MAX_INFLUENCES)) ||
                        ((inf_reg != '0) && (cur_id == 8'd0)))
                        state_reg <= S_DIV;
                    else
                        state_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    if (cnt_reg == 4'(WORDS_PER_BONE))
                        state_reg <= S_MATH;
                end
                S_MATH:
                begin
                    if (phase_reg && (step_reg == STEP_W'(NUM_UOPS - 1)))
                        state_reg <= S_NEXT;
                end
                S_DIV:
                begin
                    if ((dvd_reg < DIV_W'(WEIGHT_FULL)) && (ch_reg == 3'd5))
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_load)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                pos_reg  <= q_item.pos;
                ids_reg  <= q_item.ids;
                wts_reg  <= q_item.wts;
                inf_reg  <= '0;
                mac_reg  <= '0;
                for (int k = 0; k < 3; k++)
                    rf_reg[R_N + k] <= 32'(signed'(q_item.norm[k]));
                for (int k = 0; k < 6; k++)
                    acc_reg[k] <= '0;
            end
            S_NEXT:
            begin
                ident_reg <= (cur_id == 8'd0) || (9'(cur_id) >= 9'(BONE_COUNT));
                base_reg  <= AW'(cur_id) * AW'(WORDS_PER_BONE);
                rf_reg[R_W] <= 32'(cur_wt);
                cnt_reg   <= 4'd0;
                step_reg  <= '0;
                phase_reg <= 1'b0;
                ch_reg    <= 3'd0;
                quo_reg   <= '0;
                dvd_reg   <= DIV_W'(signed'(acc_reg[0])) + DIV_OFFSET;
            end
            S_LOAD:
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg != 4'd0)
                begin
                    if (ld_k < 4'd3)
                        rf_reg[5'(R_D) + 5'(ld_k)] <= pos_reg[ld_k[1:0]] - ld_data;
                    else if ((ld_k >= 4'd4) && (ld_k < 4'd7))
                        rf_reg[5'(R_PH) + 5'(ld_k) - 5'd4] <= ld_data;
                    else if (ld_k == 4'd7)
                        rf_reg[R_SC] <= ld_data;
                    else if (ld_k >= 4'd8)
                        rf_reg[5'(R_QX) + 5'(ld_k) - 5'd8] <= ld_data;
                end
            end
            S_MATH:
            begin
                phase_reg <= !phase_reg;
                if (!phase_reg)
                    prod_reg <= $signed(rf_reg[uop.a_sel]) * $signed(rf_reg[uop.b_sel]);
                else
                begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(NUM_UOPS - 1))
                        inf_reg <= inf_reg + INF_W'(1);
                    if (uop.wt)
                        acc_reg[uop.dst[2:0]] <= acc_reg[uop.dst[2:0]] + prod_reg[ACC_W-1:0];
                    else if (uop.last)
                    begin
                        mac_reg <= '0;
                        if ((uop.dst >= 5'(R_RP)) && (uop.dst < 5'(R_RP + 3)))
                            rf_reg[uop.dst] <= mac_sum[47:16] + rf_reg[ph_idx];
                        else
                            rf_reg[uop.dst] <= mac_sum[47:16];
                    end
                    else
                        mac_reg <= mac_sum;
                end
            end
            S_DIV:
            begin
                // 255 = 256 - 1: with x + 1 = 256*c + d, x = 255*c + (c + d - 1);
                // repeat on the remainder term until it drops below 255
                if (dvd_reg < DIV_W'(WEIGHT_FULL))
                begin
                    res_reg[ch_reg] <= quo_reg;
                    ch_reg  <= ch_reg + 3'd1;
                    quo_reg <= '0;
                    if (ch_reg != 3'd5)
                        dvd_reg <= DIV_W'(signed'(acc_reg[ch_reg + 3'd1])) + DIV_OFFSET;
                end
                else
                begin
                    quo_reg <= quo_reg + div_c[31:0];
                    dvd_reg <= div_c + DIV_W'(div_x1[7:0]) - DIV_W'(1);
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        out_pos_reg[k]  <= res_reg[k];
                        out_norm_reg[k] <= res_reg[3 + k][15:0];
                    end
                end
            end
            default:
            begin
                mac_reg <= '0;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign out_pos_x  = out_pos_reg[0];
    assign out_pos_y  = out_pos_reg[1];
    assign out_pos_z  = out_pos_reg[2];
    assign out_norm_x = out_norm_reg[0];
    assign out_norm_y = out_norm_reg[1];
    assign out_norm_z = out_norm_reg[2];

    `QSVD_CHECK(a_step_range, (state_reg != S_MATH) || (step_reg < STEP_W'(NUM_UOPS)), "bad step")
    `QSVD_CHECK(a_inf_range, inf_reg <= INF_W'(MAX_INFLUENCES), "influence index out of range")
    `QSVD_IMPLY(a_out_load, out_load, out_valid_reg && (state_reg == S_IDLE), "result lost")
    `QSVD_CHECK(a_pop_idle, !q_pop || (state_reg == S_IDLE), "queue popped while busy")

endmodule

FILE: rtl/quaternion_skinning_vertex_deformer.sv
// Top level of the quaternion-bone skinning deformer.
// Depends on qsvd_pkg, qsvd_front and qsvd_back.
//
//   channel | direction | handshake          | fields
//   in      | input     | in_valid/in_stall  | opcode, bone table word, vertex
//   out     | output    | out_valid/out_stall| deformed position and normal
//
// A table write lands in the bone table as the back end pops it; a vertex then runs,
// per used influence, a read of the bone's twelve words and 57 products on one 32x32
// multiplier, and at the end divides each of its six sums by the full weight.
// Reset clears control only; the bone table is undefined until written.
// A two-entry queue lets input beats land while the back end works or
// while a result waits on out_stall.
module quaternion_skinning_vertex_deformer
    import qsvd_pkg::*;
#(
    parameter int BONE_COUNT = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [7:0]  bone_slot,
    input  logic [3:0]  word_select,
    input  logic [31:0] word_value,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [31:0] pos_z,
    input  logic [15:0] norm_x,
    input  logic [15:0] norm_y,
    input  logic [15:0] norm_z,
    input  logic [31:0] bone_ids,
    input  logic [31:0] bone_weights,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] out_pos_x,
    output logic [31:0] out_pos_y,
    output logic [31:0] out_pos_z,
    output logic [15:0] out_norm_x,
    output logic [15:0] out_norm_y,
    output logic [15:0] out_norm_z
);

    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    qsvd_front #(.BONE_COUNT(BONE_COUNT)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .bone_slot    (bone_slot),
        .word_select  (word_select),
        .word_value   (word_value),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .norm_x       (norm_x),
        .norm_y       (norm_y),
        .norm_z       (norm_z),
        .bone_ids     (bone_ids),
        .bone_weights (bone_weights),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    qsvd_back #(.BONE_COUNT(BONE_COUNT)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_pos_x  (out_pos_x),
        .out_pos_y  (out_pos_y),
        .out_pos_z  (out_pos_z),
        .out_norm_x (out_norm_x),
        .out_norm_y (out_norm_y),
        .out_norm_z (out_norm_z)
    );

endmodule
